// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file scf_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define SCF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/scf_pkg.sv =====
// Shared types and constants for the second-chance victim selector.
// No dependencies.
package scf_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int ID_SPACE   = 64;
  localparam int FRAME_W    = 6;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_PREP,
    S_SHIFT,
    S_FINISH
  } state_t;

  // Update of the present and accessed marks.
  typedef struct packed {
    logic   pres_we;
    logic   pres_val;
    logic   acc_we;
    logic   acc_val;
    frame_t acc_id;
  } mark_cmd_t;

  typedef struct packed {
    frame_t  victim;
    status_t status;
  } result_t;

endpackage

// ===== rtl/scf_if.sv =====
// Valid/ready channel interfaces for the request and result items.
// Depends on scf_pkg for the field width.
interface scf_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [scf_pkg::FRAME_W-1:0]  frame_id;

  modport source (output valid, opcode, frame_id, input ready);
  modport sink   (input valid, opcode, frame_id, output ready);
endinterface

interface scf_out_if;
  logic                         valid;
  logic                         ready;
  logic [scf_pkg::FRAME_W-1:0]  victim_id;
  logic [1:0]                   status;

  modport source (output valid, victim_id, status, input ready);
  modport sink   (input valid, victim_id, status, output ready);
endinterface

// ===== rtl/scf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scf_marks.sv =====
// Present and accessed mark flops, one bit per frame number.
// Depends on scf_pkg.
module scf_marks (
  input  logic               clk,
  input  logic               rst_n,
  input  scf_pkg::mark_cmd_t cmd,
  input  scf_pkg::frame_t    pres_qid,
  input  scf_pkg::frame_t    acc_qid,
  output logic               pres_bit,
  output logic               acc_bit
);

  logic [scf_pkg::ID_SPACE-1:0] present_r, present_nxt;
  logic [scf_pkg::ID_SPACE-1:0] accessed_r, accessed_nxt;

  always_comb begin
    present_nxt  = present_r;
    accessed_nxt = accessed_r;
    if (cmd.pres_we) begin
      present_nxt[pres_qid] = cmd.pres_val;
    end
    if (cmd.acc_we) begin
      accessed_nxt[cmd.acc_id] = cmd.acc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      accessed_r <= '0;
    end else begin
      present_r  <= present_nxt;
      accessed_r <= accessed_nxt;
    end
  end

  assign pres_bit = present_r[pres_qid];
  assign acc_bit  = accessed_r[acc_qid];

endmodule

// ===== rtl/scf_seq.sv =====
// Sequencer: decodes an item, scans and shifts the order queue one entry
// per cycle. Depends on scf_pkg; drives scf_ram and scf_marks.
module scf_seq #(
  parameter int MAX_FRAMES = scf_pkg::MAX_FRAMES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [1:0]                    in_opcode,
  input  scf_pkg::frame_t               in_frame,
  output logic                          idle,
  output logic                          ram_we,
  output logic [$clog2(MAX_FRAMES)-1:0] ram_waddr,
  output scf_pkg::frame_t               ram_wdata,
  output logic [$clog2(MAX_FRAMES)-1:0] ram_raddr,
  input  scf_pkg::frame_t               ram_rdata,
  output scf_pkg::mark_cmd_t            mark_cmd,
  output scf_pkg::frame_t               pres_qid,
  input  logic                          pres_bit,
  input  logic                          acc_bit,
  output logic                          res_valid,
  input  logic                          res_take,
  output scf_pkg::result_t              res
);

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);

  scf_pkg::state_t  state_r, state_nxt;
  scf_pkg::op_t     op_r, op_nxt;
  scf_pkg::frame_t  id_r, id_nxt;
  scf_pkg::frame_t  head_r, head_nxt;
  scf_pkg::frame_t  victim_r, victim_nxt;
  scf_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;

  logic at_last;
  logic hit;

  assign at_last = (CW'(idx_r) == (count_r - CW'(1)));
  assign hit     = (ram_rdata == id_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scf_pkg::S_IDLE: begin
        if (in_fire) state_nxt = scf_pkg::S_DECIDE;
      end
      scf_pkg::S_DECIDE: begin
        case (op_r)
          scf_pkg::OP_REMOVE: state_nxt = pres_bit ? scf_pkg::S_SCAN : scf_pkg::S_FINISH;
          scf_pkg::OP_EVICT:  state_nxt = (count_r == '0) ? scf_pkg::S_FINISH
                                                          : scf_pkg::S_SCAN;
          default:            state_nxt = scf_pkg::S_FINISH;
        endcase
      end
      scf_pkg::S_SCAN: begin
        if (op_r == scf_pkg::OP_REMOVE) begin
          if (hit) state_nxt = scf_pkg::S_SHIFT;
          else if (at_last) state_nxt = scf_pkg::S_FINISH;
        end else begin
          if (!acc_bit) state_nxt = scf_pkg::S_SHIFT;
          else if (at_last) state_nxt = scf_pkg::S_PREP;
        end
      end
      scf_pkg::S_PREP:   state_nxt = scf_pkg::S_SHIFT;
      scf_pkg::S_SHIFT: begin
        if (at_last) state_nxt = scf_pkg::S_FINISH;
      end
      scf_pkg::S_FINISH: begin
        if (res_take) state_nxt = scf_pkg::S_IDLE;
      end
      default: state_nxt = scf_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_nxt     = op_r;
    id_nxt     = id_r;
    head_nxt   = head_r;
    victim_nxt = victim_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = AW'({1'b0, idx_r} + (AW + 1)'(1));
    mark_cmd   = '0;
    case (state_r)
      scf_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt     = scf_pkg::op_t'(in_opcode);
          id_nxt     = in_frame;
          victim_nxt = '0;
          status_nxt = scf_pkg::ST_OK;
        end
      end
      scf_pkg::S_DECIDE: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        case (op_r)
          scf_pkg::OP_INSERT: begin
            if (pres_bit || (count_r == CW'(MAX_FRAMES))) begin
              status_nxt = scf_pkg::ST_DUP;
            end else begin
              ram_we            = 1'b1;
              ram_waddr         = count_r[AW-1:0];
              ram_wdata         = id_r;
              count_nxt         = count_r + CW'(1);
              mark_cmd.pres_we  = 1'b1;
              mark_cmd.pres_val = 1'b1;
              mark_cmd.acc_we   = 1'b1;
              mark_cmd.acc_val  = 1'b0;
              mark_cmd.acc_id   = id_r;
            end
          end
          scf_pkg::OP_REMOVE: begin
            if (!pres_bit) begin
              status_nxt = scf_pkg::ST_ABSENT;
            end else begin
              mark_cmd.pres_we  = 1'b1;
              mark_cmd.pres_val = 1'b0;
              mark_cmd.acc_we   = 1'b1;
              mark_cmd.acc_val  = 1'b0;
              mark_cmd.acc_id   = id_r;
            end
          end
          scf_pkg::OP_TOUCH: begin
            if (!pres_bit) begin
              status_nxt = scf_pkg::ST_ABSENT;
            end else begin
              mark_cmd.acc_we  = 1'b1;
              mark_cmd.acc_val = 1'b1;
              mark_cmd.acc_id  = id_r;
            end
          end
          default: begin
            if (count_r == '0) status_nxt = scf_pkg::ST_EMPTY;
          end
        endcase
      end
      scf_pkg::S_SCAN: begin
        // ram_rdata holds the entry at idx_r; idx_r + 1 is already on its way
        if (idx_r == '0) head_nxt = ram_rdata;
        if (op_r == scf_pkg::OP_REMOVE) begin
          if (!hit && !at_last) idx_nxt = idx_r + AW'(1);
        end else if (acc_bit) begin
          // second chance: clear the mark and move on
          mark_cmd.acc_we  = 1'b1;
          mark_cmd.acc_val = 1'b0;
          mark_cmd.acc_id  = ram_rdata;
          if (at_last) begin
            idx_nxt    = '0;
            victim_nxt = (idx_r == '0) ? ram_rdata : head_r;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          victim_nxt = ram_rdata;
        end
      end
      scf_pkg::S_SHIFT: begin
        // ram_rdata holds the entry at idx_r + 1; close the gap at idx_r
        ram_raddr = AW'({1'b0, idx_r} + (AW + 1)'(2));
        if (at_last) begin
          if (op_r == scf_pkg::OP_EVICT) begin
            ram_we    = 1'b1;
            ram_wdata = victim_r;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          ram_we  = 1'b1;
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scf_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    head_r   <= head_nxt;
    victim_r <= victim_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
  end

  assign idle       = (state_r == scf_pkg::S_IDLE);
  assign pres_qid   = id_r;
  assign res_valid  = (state_r == scf_pkg::S_FINISH);
  assign res.victim = victim_r;
  assign res.status = status_r;

endmodule

// ===== rtl/second_chance_frame_victim_select_top.sv =====
// Top level of the second-chance victim selector: sequencer, mark flops,
// order queue RAM and result register. Depends on scf_pkg, scf_if and below.
//
//   channel  | dir | payload                  | handshake
//   in_ch    | in  | opcode[1:0], frame_id[5:0] | valid/ready
//   out_ch   | out | victim_id[5:0], status[1:0] | valid/ready
//
// Insert, touch and every error pass from accept through the decide and
// finish states to the result register. Remove and evict scan the order
// queue and then shift the gap closed; the scan and the gap shift move one
// entry per cycle. in_ch.ready is high only while the sequencer is idle.
// The result register holds a finished item while the next item is accepted.
// Reset is synchronous; marks and entry count clear at once.
module second_chance_frame_victim_select_top #(
  parameter int MAX_FRAMES = scf_pkg::MAX_FRAMES
) (
  input logic       clk,
  input logic       rst_n,
  scf_in_if.sink    in_ch,
  scf_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_FRAMES);

  logic                 in_fire;
  logic                 idle;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  scf_pkg::frame_t      ram_wdata;
  scf_pkg::frame_t      ram_rdata;
  scf_pkg::mark_cmd_t   mark_cmd;
  scf_pkg::frame_t      pres_qid;
  logic                 pres_bit;
  logic                 acc_bit;
  logic                 res_valid;
  logic                 res_take;
  scf_pkg::result_t     res;

  logic                 out_valid_r, out_valid_nxt;
  scf_pkg::result_t     out_res_r, out_res_nxt;

  assign in_ch.ready = idle && rst_n;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign res_take    = !out_valid_r || out_ch.ready;

  scf_seq #(.MAX_FRAMES(MAX_FRAMES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_opcode (in_ch.opcode),
    .in_frame  (in_ch.frame_id),
    .idle      (idle),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .mark_cmd  (mark_cmd),
    .pres_qid  (pres_qid),
    .pres_bit  (pres_bit),
    .acc_bit   (acc_bit),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  scf_marks u_marks (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mark_cmd),
    .pres_qid (pres_qid),
    .acc_qid  (ram_rdata),
    .pres_bit (pres_bit),
    .acc_bit  (acc_bit)
  );

  scf_ram #(.WIDTH(scf_pkg::FRAME_W), .DEPTH(MAX_FRAMES)) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: load when the sequencer finishes, drop on take
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.victim_id = out_res_r.victim;
  assign out_ch.status    = out_res_r.status;

endmodule

// ===== rtl/scf_chk.sv =====
// Port-level checker for the second-chance victim selector, bound to the top.
// Depends on scf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_victim_id,
  input logic [1:0] out_status
);

  // An accepted item drops ready in the cycle after the accept
  `SCF_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "ready after accept")

  // Errors carry no victim: the victim id is zero on any non-OK status
  `SCF_ASSERT_NEVER(a_err_no_victim, clk, rst_n, out_valid && (out_status != 2'(scf_pkg::ST_OK)) && (out_victim_id != '0), "victim on error")

  // Hold a stalled result item
  `SCF_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_victim_id) && $stable(out_status)), "result changed under stall")

endmodule

bind second_chance_frame_victim_select_top scf_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_victim_id (out_ch.victim_id),
  .out_status    (out_ch.status)
);
